// ===== rtl/bir_pkg.sv =====
// shared types, constants and codes for the bilinear image resizer
package bir_pkg;

	localparam int MAX_WIDTH     = 128;
	localparam int MAX_HEIGHT    = 128;
	localparam int MAX_CHANNELS  = 3;
	localparam int FRACTION_BITS = 16;
	localparam int TARGET_LIMIT  = 4096;

	localparam int SRC_W   = 8;
	localparam int CH_W    = 2;
	localparam int TGT_W   = 13;
	localparam int CNT_W   = 12;
	localparam int PIX_W   = 8;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 3;

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int POS_W       = SRC_W + FRACTION_BITS;
	localparam int WGT_W       = FRACTION_BITS + 1;
	localparam int PROD_W      = WGT_W + PIX_W;
	localparam int ACC_W       = 2 * FRACTION_BITS + PIX_W;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd4;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] sample;
	} in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [CNT_W-1:0] out_row;
		logic [CNT_W-1:0] out_col;
		logic [CH_W-1:0]  out_channel;
		logic             last;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TAP,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       tap_issue;
		logic [1:0] tap_idx;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/bir_div.sv =====
// restoring divider, one quotient bit per cycle, for the position steps
module bir_div (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [bir_pkg::POS_W-1:0]                  dividend,
	input  logic [bir_pkg::TGT_W-1:0]                  divisor,
	output logic                                       busy,
	output logic [bir_pkg::POS_W-1:0]                  quotient
);

	localparam int DIV_CNT_W = $clog2(bir_pkg::POS_W + 1);

	logic [bir_pkg::POS_W-1:0] num_q;
	logic [bir_pkg::POS_W-1:0] quo_q;
	logic [bir_pkg::TGT_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0]      cnt_q;
	logic                      busy_q;
	logic [bir_pkg::TGT_W:0]   trial;
	logic [bir_pkg::TGT_W:0]   diff;
	logic                      fits;

	assign trial = {rem_q, num_q[bir_pkg::POS_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(bir_pkg::POS_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != DIV_CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[bir_pkg::POS_W-2:0], 1'b0};
			rem_q <= fits ? diff[bir_pkg::TGT_W-1:0] : trial[bir_pkg::TGT_W-1:0];
			quo_q <= {quo_q[bir_pkg::POS_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/bir_ctrl.sv =====
// sequencer: load, four tap reads, pipeline drain and result hand-off
module bir_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_cmd,
	input  bir_pkg::dp_stat_t  stat,
	output logic               in_ready,
	output bir_pkg::dp_cmd_t   cmd
);

	bir_pkg::state_t state_q, state_d;
	logic [1:0]      cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bir_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			bir_pkg::ST_IDLE: begin
				in_ready = !stat.busy;
				if (in_valid && !stat.busy) begin
					if (in_cmd == bir_pkg::CMD_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						state_d = bir_pkg::ST_TAP;
						cnt_d   = '0;
					end
				end
			end
			bir_pkg::ST_TAP: begin
				cmd.tap_issue = 1'b1;
				cmd.tap_idx   = cnt_q;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					state_d = bir_pkg::ST_DRAIN;
					cnt_d   = '0;
				end
			end
			bir_pkg::ST_DRAIN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == 2'd1) begin
					state_d = bir_pkg::ST_OUT;
				end
			end
			bir_pkg::ST_OUT: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = bir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bir_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/bir_dp.sv =====
// datapath: registers, source store, counters, step dividers and weighted sum
module bir_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bir_pkg::dp_cmd_t                  cmd,
	output bir_pkg::dp_stat_t                 stat,
	input  bir_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bir_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bir_pkg::CFG_W-1:0]         cfg_data
);

	localparam int F = bir_pkg::FRACTION_BITS;
	localparam logic [bir_pkg::WGT_W-1:0] ONE = bir_pkg::WGT_W'(1) << F;

	// raw register values
	logic [bir_pkg::SRC_W-1:0] src_w_q, src_h_q;
	logic [bir_pkg::CH_W-1:0]  chan_q;
	logic [bir_pkg::TGT_W-1:0] tgt_w_q, tgt_h_q;
	logic                      init_q;

	// saturated sizes
	logic [bir_pkg::SRC_W-1:0] sw, sh;
	logic [bir_pkg::CH_W-1:0]  cc;
	logic [bir_pkg::TGT_W-1:0] tw, th;

	logic                        cfg_we, restart;
	logic                        restart_q_d;
	logic                        div_x_busy, div_y_busy;
	logic [bir_pkg::POS_W-1:0]   step_x, step_y;

	logic [bir_pkg::ADDR_W-1:0]  load_ptr_q;
	logic [bir_pkg::ADDR_W:0]    load_next;
	logic [bir_pkg::ADDR_W+2:0]  img_size;
	logic [bir_pkg::CNT_W-1:0]   row_q, col_q;
	logic [bir_pkg::CH_W-1:0]    ch_q;
	logic [bir_pkg::POS_W-1:0]   vpos_q, hpos_q;

	logic [bir_pkg::PIX_W-1:0]   store [bir_pkg::STORE_DEPTH];

	logic [bir_pkg::SRC_W-1:0]   xi, yi, tx, ty;
	logic [F-1:0]                fx, fy;
	logic                        edge_hit;
	logic [bir_pkg::WGT_W-1:0]   wx0, wx1, wy0, wy1;
	logic [2*bir_pkg::SRC_W-1:0] line_base;
	logic [2*bir_pkg::SRC_W-1:0] pix_idx;
	logic [bir_pkg::ADDR_W+1:0]  addr_full;
	logic [bir_pkg::ADDR_W-1:0]  rd_addr;

	logic [bir_pkg::PIX_W-1:0]   rd_s1;
	logic [1:0]                  tap_s1, tap_s2;
	logic                        vld_s1, vld_s2;
	logic [bir_pkg::PROD_W-1:0]  prod_s2;
	logic [bir_pkg::ACC_W-1:0]   acc_q;
	logic [bir_pkg::WGT_W-1:0]   wx_s1, wy_s2;
	logic [bir_pkg::WGT_W+bir_pkg::PROD_W-1:0] term;

	logic                        out_valid_q;
	bir_pkg::out_t               out_q;
	logic                        last_ch, last_col, last_row;

	always_comb begin
		sw = (src_w_q == '0) ? bir_pkg::SRC_W'(1) :
		     (src_w_q > bir_pkg::SRC_W'(bir_pkg::MAX_WIDTH)) ?
		     bir_pkg::SRC_W'(bir_pkg::MAX_WIDTH) : src_w_q;
		sh = (src_h_q == '0) ? bir_pkg::SRC_W'(1) :
		     (src_h_q > bir_pkg::SRC_W'(bir_pkg::MAX_HEIGHT)) ?
		     bir_pkg::SRC_W'(bir_pkg::MAX_HEIGHT) : src_h_q;
		cc = (chan_q == '0) ? bir_pkg::CH_W'(1) :
		     (chan_q > bir_pkg::CH_W'(bir_pkg::MAX_CHANNELS)) ?
		     bir_pkg::CH_W'(bir_pkg::MAX_CHANNELS) : chan_q;
		tw = (tgt_w_q == '0) ? bir_pkg::TGT_W'(1) :
		     (tgt_w_q > bir_pkg::TGT_W'(bir_pkg::TARGET_LIMIT)) ?
		     bir_pkg::TGT_W'(bir_pkg::TARGET_LIMIT) : tgt_w_q;
		th = (tgt_h_q == '0) ? bir_pkg::TGT_W'(1) :
		     (tgt_h_q > bir_pkg::TGT_W'(bir_pkg::TARGET_LIMIT)) ?
		     bir_pkg::TGT_W'(bir_pkg::TARGET_LIMIT) : tgt_h_q;
	end

	// writes to indexes past the list are dropped without a restart
	assign cfg_we  = cfg_valid && (cfg_index <= bir_pkg::CFG_TARGET_HEIGHT);
	assign restart = cfg_we || init_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= bir_pkg::SRC_W'(128);
			src_h_q <= bir_pkg::SRC_W'(128);
			chan_q  <= bir_pkg::CH_W'(3);
			tgt_w_q <= bir_pkg::TGT_W'(128);
			tgt_h_q <= bir_pkg::TGT_W'(128);
			init_q  <= 1'b1;
		end else begin
			init_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					bir_pkg::CFG_SOURCE_WIDTH:  src_w_q <= cfg_data[bir_pkg::SRC_W-1:0];
					bir_pkg::CFG_SOURCE_HEIGHT: src_h_q <= cfg_data[bir_pkg::SRC_W-1:0];
					bir_pkg::CFG_CHANNEL_COUNT: chan_q  <= cfg_data[bir_pkg::CH_W-1:0];
					bir_pkg::CFG_TARGET_WIDTH:  tgt_w_q <= cfg_data;
					bir_pkg::CFG_TARGET_HEIGHT: tgt_h_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// steps are recomputed from the current registers after every restart
	bir_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (init_q || restart_q_d),
		.dividend ({sw, F'(0)}),
		.divisor  (tw),
		.busy     (div_x_busy),
		.quotient (step_x)
	);

	bir_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (init_q || restart_q_d),
		.dividend ({sh, F'(0)}),
		.divisor  (th),
		.busy     (div_y_busy),
		.quotient (step_y)
	);

	// divide in the cycle after the write so the new register value is used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q_d <= 1'b0;
		end else begin
			restart_q_d <= cfg_we;
		end
	end

	assign stat.busy     = div_x_busy || div_y_busy || restart || restart_q_d;
	assign stat.out_free = !out_valid_q || out_ready;

	// load pointer
	assign img_size  = (bir_pkg::ADDR_W+3)'(sw) * (bir_pkg::ADDR_W+3)'(sh)
	                 * (bir_pkg::ADDR_W+3)'(cc);
	assign load_next = {1'b0, load_ptr_q} + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			store[load_ptr_q] <= in_data.sample;
		end
		if (cmd.tap_issue) begin
			rd_s1 <= store[rd_addr];
		end
	end

	// tap address
	assign xi = hpos_q[bir_pkg::POS_W-1:F];
	assign yi = vpos_q[bir_pkg::POS_W-1:F];
	assign fx = hpos_q[F-1:0];
	assign fy = vpos_q[F-1:0];
	assign edge_hit = ({1'b0, xi} + 1'b1 >= {1'b0, sw}) ||
	                  ({1'b0, yi} + 1'b1 >= {1'b0, sh});

	assign tx = xi + bir_pkg::SRC_W'(cmd.tap_idx[0] && !edge_hit);
	assign ty = yi + bir_pkg::SRC_W'(cmd.tap_idx[1] && !edge_hit);
	assign line_base = ty * sw;
	assign pix_idx   = line_base + (2*bir_pkg::SRC_W)'(tx);
	assign addr_full = (bir_pkg::ADDR_W+2)'(pix_idx) * (bir_pkg::ADDR_W+2)'(cc)
	                 + (bir_pkg::ADDR_W+2)'(ch_q);
	assign rd_addr   = addr_full[bir_pkg::ADDR_W-1:0];

	// at an edge the top-left sample takes the full weight
	assign wx0 = edge_hit ? ONE : ONE - bir_pkg::WGT_W'(fx);
	assign wx1 = edge_hit ? '0  : bir_pkg::WGT_W'(fx);
	assign wy0 = edge_hit ? ONE : ONE - bir_pkg::WGT_W'(fy);
	assign wy1 = edge_hit ? '0  : bir_pkg::WGT_W'(fy);

	assign wx_s1 = tap_s1[0] ? wx1 : wx0;
	assign wy_s2 = tap_s2[1] ? wy1 : wy0;
	assign term  = wy_s2 * prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.tap_issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1  <= cmd.tap_idx;
		tap_s2  <= tap_s1;
		prod_s2 <= wx_s1 * rd_s1;
		if (cmd.tap_issue && cmd.tap_idx == 2'd0) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + term[bir_pkg::ACC_W-1:0];
		end
	end

	// emission counters
	assign last_ch  = ({1'b0, ch_q} + 1'b1) == {1'b0, cc};
	assign last_col = ({1'b0, col_q} + 1'b1) == tw;
	assign last_row = ({1'b0, row_q} + 1'b1) == th;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q  <= '0;
			row_q       <= '0;
			col_q       <= '0;
			ch_q        <= '0;
			vpos_q      <= '0;
			hpos_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				load_ptr_q <= '0;
				row_q      <= '0;
				col_q      <= '0;
				ch_q       <= '0;
				vpos_q     <= '0;
				hpos_q     <= '0;
			end else begin
				if (cmd.load) begin
					load_ptr_q <= ((bir_pkg::ADDR_W+3)'(load_next) >= img_size) ?
					              '0 : load_next[bir_pkg::ADDR_W-1:0];
				end
				if (cmd.finish) begin
					if (last_ch) begin
						ch_q <= '0;
						if (last_col) begin
							col_q  <= '0;
							hpos_q <= '0;
							if (last_row) begin
								row_q  <= '0;
								vpos_q <= '0;
							end else begin
								row_q  <= row_q + 1'b1;
								vpos_q <= vpos_q + step_y;
							end
						end else begin
							col_q  <= col_q + 1'b1;
							hpos_q <= hpos_q + step_x;
						end
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.pixel       <= acc_q[2*F +: bir_pkg::PIX_W];
			out_q.out_row     <= row_q;
			out_q.out_col     <= col_q;
			out_q.out_channel <= ch_q;
			out_q.last        <= last_ch && last_col && last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken one");

	a_no_work_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load || cmd.tap_issue) |-> !(div_x_busy || div_y_busy))
		else $error("item handled while steps are computed");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bir_pkg::ADDR_W+3)'(load_ptr_q) < img_size)
		else $error("load pointer past image size");

	a_pix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (acc_q[bir_pkg::ACC_W-1:2*F] <= bir_pkg::PIX_W'(255)))
		else $error("weighted sum out of range");

endmodule

// ===== rtl/bilinear_image_resize.sv =====
// top level of the bilinear image resizer
//
//  channel   signals                          direction  transaction
//  in        in_valid in_ready in_data        sink       load one sample or request one
//  out       out_valid out_ready out_data     source     one resized sample
//  cfg       cfg_valid cfg_ready cfg_index    sink       one register write
//            cfg_data
//
// a load is written while the sequencer stays idle; a request's result is valid
// after four tap reads of the source store, the product and accumulator
// registers of the multiply pipeline and the result register; the next
// transaction is taken once the result is registered, so a request occupies the
// input until then; the two step dividers run after reset and after each
// register write, and in_ready is low from either until both are done
// a waiting result holds a request in its final state with in_ready low;
// loads go on while no request is in flight
// the source store has no reset; samples never loaded read as anything
module bilinear_image_resize (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bir_pkg::in_t                      in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bir_pkg::out_t                     out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bir_pkg::CFG_W-1:0]         cfg_data
);

	bir_pkg::dp_cmd_t  cmd;
	bir_pkg::dp_stat_t stat;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer
	bir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// storage and arithmetic
	bir_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
